// File: design/mse_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the MIPS32 subset executor.
// No dependencies; every other design file imports this package.
package mse_pkg;

    localparam int unsigned MEM_BYTES = 65536;
    localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
    localparam int unsigned DMEM_AW   = $clog2(MEM_WORDS);
    localparam int unsigned RF_DEPTH  = 32;

    localparam logic [4:0] RA_IDX = 5'd31;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYSCALL = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    typedef enum logic [1:0] {
        SZ_B,
        SZ_H,
        SZ_W
    } t_size;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic               en;
        logic [DMEM_AW-1:0] idx;
        logic [3:0]         be;
        logic [31:0]        data;
    } t_dm_wr;

    // Everything the execute stage decides for one instruction
    typedef struct packed {
        logic [31:0]        npc;
        logic               wr;
        logic [4:0]         widx;
        logic [31:0]        wval;
        logic               mul_en;
        logic [31:0]        hi;
        logic [31:0]        lo;
        logic               ld_en;
        t_size              ld_size;
        logic               ld_sgn;
        logic [1:0]         boff;
        logic [DMEM_AW-1:0] mem_idx;
        logic               st_en;
        logic [3:0]         be;
        logic [31:0]        wdata;
        logic [31:0]        maddr;
        logic [31:0]        mdata;
        logic [1:0]         status;
    } t_ex_res;

    // One result item as delivered
    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic [31:0] hi;
        logic [31:0] lo;
        logic        mw;
        logic [31:0] maddr;
        logic [31:0] mdata;
        logic [1:0]  status;
    } t_res;

    typedef struct packed {
        t_res       res;
        logic       ld_en;
        t_size      ld_size;
        logic       ld_sgn;
        logic [1:0] boff;
    } t_wb;

endpackage

// File: design/mse_regfile.sv
`timescale 1ns / 1ps
// General register file: 32 x 32 synchronous RAM, two read ports, one write port.
// Depends on mse_pkg.
module mse_regfile (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  logic [4:0]     i_ra_a,
    input  logic [4:0]     i_ra_b,
    input  mse_pkg::t_rf_wr i_wr,
    output logic [31:0]    o_rd_a,
    output logic [31:0]    o_rd_b
);
    import mse_pkg::*;

    logic [31:0]         mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] r_vld;
    logic [31:0]         r_qa, r_qb, r_bdat;
    logic                r_va, r_vb, r_bya, r_byb;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_qa   <= mem[i_ra_a];
            r_qb   <= mem[i_ra_b];
            r_bdat <= i_wr.data;
        end
    end

    // Valid bits stand in for the all-zero reset; a same-edge write bypasses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_bya <= 1'b0;
            r_byb <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_va  <= r_vld[i_ra_a];
                r_vb  <= r_vld[i_ra_b];
                r_bya <= i_wr.en && (i_wr.idx == i_ra_a);
                r_byb <= i_wr.en && (i_wr.idx == i_ra_b);
            end
        end
    end

    assign o_rd_a = r_bya ? r_bdat : (r_va ? r_qa : '0);
    assign o_rd_b = r_byb ? r_bdat : (r_vb ? r_qb : '0);

endmodule

// File: design/mse_dmem.sv
`timescale 1ns / 1ps
// Data memory: byte-enabled word RAM with registered read and a clearing pass after reset.
// Depends on mse_pkg.
module mse_dmem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mse_pkg::t_dm_wr             i_wr,
    input  logic                        i_rd_en,
    input  logic [mse_pkg::DMEM_AW-1:0] i_rd_idx,
    output logic [31:0]                 o_rd_data,
    output logic                        o_clr_busy
);
    import mse_pkg::*;

    logic [3:0][7:0]    mem [MEM_WORDS];
    logic               r_clr_busy;
    logic [DMEM_AW-1:0] r_clr_idx;
    logic [31:0]        r_rdata;
    t_dm_wr             wr;

    always_comb begin
        wr = i_wr;
        if (r_clr_busy) begin
            wr.en   = 1'b1;
            wr.idx  = r_clr_idx;
            wr.be   = '1;
            wr.data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr.en) begin
            for (int i = 0; i < 4; i++) begin
                if (wr.be[i]) begin
                    mem[wr.idx][i] <= wr.data[i*8 +: 8];
                end
            end
        end
        if (i_rd_en) begin
            r_rdata <= mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == DMEM_AW'(MEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_rd_data  = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

// File: design/mse_exu.sv
`timescale 1ns / 1ps
// Execute unit: decode, ALU, multiplier, branch target and address check for one instruction.
// Depends on mse_pkg.
module mse_exu (
    input  logic [31:0]       i_instr,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    input  logic [31:0]       i_pc,
    input  logic [31:0]       i_hi,
    input  logic [31:0]       i_lo,
    output mse_pkg::t_ex_res  o_res
);
    import mse_pkg::*;

    logic [5:0]         op, fn;
    logic [4:0]         rt, rd, sh;
    logic [15:0]        imm;
    logic [31:0]        simm, zimm, ea, pc4, jtgt, btgt;
    logic               mem_op, ld, sgn, mul_sgn, aligned, addr_ok;
    t_size              size;
    logic [2:0]         nbytes;
    logic [32:0]        ea_end;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    t_ex_res            r;

    assign op   = i_instr[31:26];
    assign rt   = i_instr[20:16];
    assign rd   = i_instr[15:11];
    assign sh   = i_instr[10:6];
    assign fn   = i_instr[5:0];
    assign imm  = i_instr[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign zimm = {16'd0, imm};
    assign ea   = i_a + simm;
    assign pc4  = i_pc + 32'd4;
    assign jtgt = {pc4[31:28], i_instr[25:0], 2'b00};
    assign btgt = pc4 + {simm[29:0], 2'b00};

    assign mul_sgn = (fn == FN_MULT);
    assign ma      = {mul_sgn & i_a[31], i_a};
    assign mb      = {mul_sgn & i_b[31], i_b};
    assign prod    = ma * mb;

    always_comb begin
        r         = '0;
        r.npc     = pc4;
        r.status  = ST_OK;
        r.hi      = i_hi;
        r.lo      = i_lo;
        r.mem_idx = ea[DMEM_AW+1:2];
        r.boff    = ea[1:0];
        mem_op    = 1'b0;
        ld        = 1'b0;
        sgn       = 1'b0;
        size      = SZ_W;

        unique case (op)
            OP_SPECIAL: begin
                r.wr   = 1'b1;
                r.widx = rd;
                unique case (fn)
                    FN_SLL:  r.wval = i_b << sh;
                    FN_SRL:  r.wval = i_b >> sh;
                    FN_SRA:  r.wval = 32'($signed(i_b) >>> sh);
                    FN_JR: begin
                        r.wr  = 1'b0;
                        r.npc = i_a;
                    end
                    FN_JALR: begin
                        r.wval = pc4;
                        r.npc  = i_a;
                    end
                    FN_SYSCALL: begin
                        r.wr     = 1'b0;
                        r.status = ST_SYSCALL;
                    end
                    FN_MFHI: r.wval = i_hi;
                    FN_MFLO: r.wval = i_lo;
                    FN_MULT, FN_MULTU: begin
                        r.wr     = 1'b0;
                        r.mul_en = 1'b1;
                        r.hi     = prod[63:32];
                        r.lo     = prod[31:0];
                    end
                    FN_ADDU: r.wval = i_a + i_b;
                    FN_SUBU: r.wval = i_a - i_b;
                    FN_AND:  r.wval = i_a & i_b;
                    FN_OR:   r.wval = i_a | i_b;
                    FN_XOR:  r.wval = i_a ^ i_b;
                    FN_NOR:  r.wval = ~(i_a | i_b);
                    FN_SLT:  r.wval = {31'd0, $signed(i_a) < $signed(i_b)};
                    FN_SLTU: r.wval = {31'd0, i_a < i_b};
                    default: begin
                        r.wr     = 1'b0;
                        r.status = ST_ILLEGAL;
                    end
                endcase
            end
            default: begin
                r.wr   = 1'b1;
                r.widx = rt;
                unique case (op)
                    OP_J: begin
                        r.wr  = 1'b0;
                        r.npc = jtgt;
                    end
                    OP_JAL: begin
                        r.widx = RA_IDX;
                        r.wval = pc4;
                        r.npc  = jtgt;
                    end
                    OP_BEQ: begin
                        r.wr = 1'b0;
                        if (i_a == i_b) begin
                            r.npc = btgt;
                        end
                    end
                    OP_BNE: begin
                        r.wr = 1'b0;
                        if (i_a != i_b) begin
                            r.npc = btgt;
                        end
                    end
                    OP_ADDIU: r.wval = i_a + simm;
                    OP_SLTI:  r.wval = {31'd0, $signed(i_a) < $signed(simm)};
                    OP_SLTIU: r.wval = {31'd0, i_a < simm};
                    OP_ANDI:  r.wval = i_a & zimm;
                    OP_ORI:   r.wval = i_a | zimm;
                    OP_XORI:  r.wval = i_a ^ zimm;
                    OP_LUI:   r.wval = {imm, 16'd0};
                    OP_LB: begin
                        mem_op = 1'b1; ld = 1'b1; size = SZ_B; sgn = 1'b1;
                    end
                    OP_LH: begin
                        mem_op = 1'b1; ld = 1'b1; size = SZ_H; sgn = 1'b1;
                    end
                    OP_LW: begin
                        mem_op = 1'b1; ld = 1'b1; size = SZ_W;
                    end
                    OP_LBU: begin
                        mem_op = 1'b1; ld = 1'b1; size = SZ_B;
                    end
                    OP_LHU: begin
                        mem_op = 1'b1; ld = 1'b1; size = SZ_H;
                    end
                    OP_SB: begin
                        mem_op = 1'b1; size = SZ_B;
                    end
                    OP_SH: begin
                        mem_op = 1'b1; size = SZ_H;
                    end
                    OP_SW: begin
                        mem_op = 1'b1; size = SZ_W;
                    end
                    default: begin
                        r.wr     = 1'b0;
                        r.status = ST_ILLEGAL;
                    end
                endcase
            end
        endcase

        // Access size, alignment and bound over the whole access
        case (size)
            SZ_B: begin
                nbytes  = 3'd1;
                aligned = 1'b1;
                r.be    = 4'b0001 << ea[1:0];
                r.wdata = {4{i_b[7:0]}};
                r.mdata = {24'd0, i_b[7:0]};
            end
            SZ_H: begin
                nbytes  = 3'd2;
                aligned = !ea[0];
                r.be    = ea[1] ? 4'b1100 : 4'b0011;
                r.wdata = {2{i_b[15:0]}};
                r.mdata = {16'd0, i_b[15:0]};
            end
            default: begin
                nbytes  = 3'd4;
                aligned = (ea[1:0] == 2'b00);
                r.be    = 4'b1111;
                r.wdata = i_b;
                r.mdata = i_b;
            end
        endcase
        ea_end  = {1'b0, ea} + {30'd0, nbytes};
        addr_ok = (ea != 32'd0) && aligned && (ea_end <= 33'(MEM_BYTES));

        if (mem_op) begin
            r.maddr = ea;
            if (!addr_ok) begin
                r.wr     = 1'b0;
                r.status = ST_BADADDR;
            end else if (ld) begin
                r.ld_en   = 1'b1;
                r.ld_size = size;
                r.ld_sgn  = sgn;
            end else begin
                r.wr    = 1'b0;
                r.st_en = 1'b1;
            end
        end
        if (!r.st_en) begin
            r.mdata = '0;
        end

        if (r.status == ST_ILLEGAL || r.status == ST_BADADDR) begin
            r.npc = i_pc;
        end
        if (r.widx == 5'd0) begin
            r.wr = 1'b0;
        end
        if (!r.wr) begin
            r.widx  = '0;
            r.wval  = '0;
            r.ld_en = 1'b0;
        end
        o_res = r;
    end

endmodule

// File: design/mips32_subset_executor.sv
`timescale 1ns / 1ps
// Top level of the MIPS32 subset executor; instantiates mse_regfile, mse_dmem and mse_exu.
// Depends on mse_pkg.
//
// Executes one MIPS32 instruction word per transfer on the input channel (i_valid/o_ready)
// and returns one result per instruction on the output channel (o_valid/i_ready), in order.
// Instructions flow through three stages: register read (the register file RAM is read on
// the accepting edge), execute (ALU, 32x32 multiplier, branch target, address check, store
// into data memory, load address issued) and write-back (load data aligned, register file
// written), followed by an output register so a finished result can wait while the next
// instruction is taken. Throughput is one instruction per cycle for everything but loads,
// as long as the output is taken; a load holds the input while it sits in execute and
// write-back, because its data arrives from the data memory read port only in write-back
// and is not forwarded. After reset the data memory is cleared one word per cycle,
// MEM_BYTES/4 = 16384 words, during which o_ready stays low (start_address writes are
// still taken). Writing start_address loads the PC; do so only while the block is idle.
module mips32_subset_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_next_pc,
    output logic        o_reg_write,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic [31:0] o_hi_value,
    output logic [31:0] o_lo_value,
    output logic        o_mem_write,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_mem_data,
    output logic [1:0]  o_status
);
    import mse_pkg::*;

    // Stage valids and payloads
    logic        r_ex_vld, r_wb_vld, r_out_vld;
    logic [31:0] r_ex_instr;
    t_wb         r_wb;
    t_res        r_out;
    logic [31:0] r_pc, r_hi, r_lo;

    logic        accept, out_free, wb_move, wb_free, ex_move, clr_busy;
    logic [31:0] rf_a, rf_b, op_a, op_b, dm_rdata, ld_shift, ld_val;
    t_ex_res     ex;
    t_rf_wr      rf_wr;
    t_dm_wr      dm_wr;
    t_res        wb_res;

    // Handshake and stage advance: each stage moves when the one after it is free
    assign out_free = !r_out_vld || i_ready;
    assign wb_move  = r_wb_vld && out_free;
    assign wb_free  = !r_wb_vld || out_free;
    assign ex_move  = r_ex_vld && wb_free;
    // Hold the input while a load sits in execute or write-back: its data is not forwarded
    assign o_ready  = !clr_busy && (!r_ex_vld || ex_move)
                    && !(r_ex_vld && ex.ld_en) && !(r_wb_vld && r_wb.ld_en);
    assign accept   = i_valid && o_ready;

    mse_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_ra_a  (i_instr_word[25:21]),
        .i_ra_b  (i_instr_word[20:16]),
        .i_wr    (rf_wr),
        .o_rd_a  (rf_a),
        .o_rd_b  (rf_b)
    );

    // Forward a pending write-back result into execute
    always_comb begin
        op_a = rf_a;
        op_b = rf_b;
        if (r_wb_vld && r_wb.res.wr && (r_wb.res.widx == r_ex_instr[25:21])) begin
            op_a = r_wb.res.wval;
        end
        if (r_wb_vld && r_wb.res.wr && (r_wb.res.widx == r_ex_instr[20:16])) begin
            op_b = r_wb.res.wval;
        end
    end

    mse_exu u_exu (
        .i_instr (r_ex_instr),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_pc    (r_pc),
        .i_hi    (r_hi),
        .i_lo    (r_lo),
        .o_res   (ex)
    );

    // Stores commit at the end of execute, so a following load already sees them
    always_comb begin
        dm_wr.en   = ex_move && ex.st_en;
        dm_wr.idx  = ex.mem_idx;
        dm_wr.be   = ex.be;
        dm_wr.data = ex.wdata;
    end

    mse_dmem u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (dm_wr),
        .i_rd_en    (ex_move && ex.ld_en),
        .i_rd_idx   (ex.mem_idx),
        .o_rd_data  (dm_rdata),
        .o_clr_busy (clr_busy)
    );

    // Load alignment and extension in write-back
    always_comb begin
        ld_shift = dm_rdata >> {r_wb.boff, 3'b000};
        case (r_wb.ld_size)
            SZ_B:    ld_val = {{24{r_wb.ld_sgn & ld_shift[7]}}, ld_shift[7:0]};
            SZ_H:    ld_val = {{16{r_wb.ld_sgn & ld_shift[15]}}, ld_shift[15:0]};
            default: ld_val = dm_rdata;
        endcase
        wb_res = r_wb.res;
        if (r_wb.ld_en) begin
            wb_res.wval = ld_val;
        end
        rf_wr.en   = wb_move && wb_res.wr;
        rf_wr.idx  = wb_res.widx;
        rf_wr.data = wb_res.wval;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pc      <= '0;
            r_hi      <= '0;
            r_lo      <= '0;
        end else begin
            if (accept) begin
                r_ex_vld <= 1'b1;
            end else if (ex_move) begin
                r_ex_vld <= 1'b0;
            end
            if (ex_move) begin
                r_wb_vld <= 1'b1;
            end else if (wb_move) begin
                r_wb_vld <= 1'b0;
            end
            if (wb_move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            // Architectural PC, HI and LO advance at the end of execute
            if (i_cfg_we) begin
                r_pc <= i_cfg_data;
            end else if (ex_move) begin
                r_pc <= ex.npc;
            end
            if (ex_move && ex.mul_en) begin
                r_hi <= ex.hi;
                r_lo <= ex.lo;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex_instr <= i_instr_word;
        end
        if (ex_move) begin
            r_wb.res.npc    <= ex.npc;
            r_wb.res.wr     <= ex.wr;
            r_wb.res.widx   <= ex.widx;
            r_wb.res.wval   <= ex.wval;
            r_wb.res.hi     <= ex.hi;
            r_wb.res.lo     <= ex.lo;
            r_wb.res.mw     <= ex.st_en;
            r_wb.res.maddr  <= ex.maddr;
            r_wb.res.mdata  <= ex.mdata;
            r_wb.res.status <= ex.status;
            r_wb.ld_en      <= ex.ld_en;
            r_wb.ld_size    <= ex.ld_size;
            r_wb.ld_sgn     <= ex.ld_sgn;
            r_wb.boff       <= ex.boff;
        end
        if (wb_move) begin
            r_out <= wb_res;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_next_pc     = r_out.npc;
    assign o_reg_write   = r_out.wr;
    assign o_reg_index   = r_out.widx;
    assign o_reg_value   = r_out.wval;
    assign o_hi_value    = r_out.hi;
    assign o_lo_value    = r_out.lo;
    assign o_mem_write   = r_out.mw;
    assign o_mem_address = r_out.maddr;
    assign o_mem_data    = r_out.mdata;
    assign o_status      = r_out.status;

endmodule

// File: design/mse_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the MIPS32 subset executor, bound to the top level.
// Depends on mse_pkg.
module mse_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [31:0] i_cfg_data,
    input logic        i_valid,
    input logic        o_ready,
    input logic [31:0] i_instr_word,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_next_pc,
    input logic        o_reg_write,
    input logic [4:0]  o_reg_index,
    input logic [31:0] o_reg_value,
    input logic [31:0] o_hi_value,
    input logic [31:0] o_lo_value,
    input logic        o_mem_write,
    input logic [31:0] o_mem_address,
    input logic [31:0] o_mem_data,
    input logic [1:0]  o_status
);
    import mse_pkg::*;

    // Faulting instructions change neither registers nor memory
    a_fault_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ILLEGAL || o_status == ST_BADADDR)
        |-> !o_reg_write && !o_mem_write)
        else $error("faulting instruction reported a write");

    // Register zero is never reported as written
    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reg_write |-> o_reg_index != 5'd0)
        else $error("write to register zero reported");

    // Without a register write, index and value read zero
    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_reg_write |-> o_reg_index == 5'd0 && o_reg_value == 32'd0)
        else $error("stale register write fields");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_next_pc) && $stable(o_status))
        else $error("result changed while stalled");

    // No input is taken in the cycle after reset: the memory clear is running
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("block ready during memory clear");

endmodule

bind mips32_subset_executor mse_chk u_mse_chk (.*);
